>>> rtl/swm_pkg.sv
// Package for the sliding window median filter.
// Holds the configuration register map, reset values and the cell control word.
// Depends on nothing; the cell, history and top-level files of the block use it.
package swm_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int WS_W       = 7;

    localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE = 2'd0;
    localparam logic [WS_W-1:0]       WINDOW_SIZE_RST  = 7'd5;

    typedef struct packed {
        logic clr;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

>>> rtl/swm_if.sv
// Stream interfaces for the sliding window median filter.
// One carries a sample word in, the other a median word out; no dependencies.
interface swm_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

>>> rtl/swm_cell.sv
// One cell of the sorted chain: holds a single sample and its valid bit.
// Inserts by shifting towards higher ranks, retires by shifting back. Uses swm_pkg.
module swm_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swm_pkg::t_cell_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_v,
    input  logic                          i_prev_valid,
    input  logic                          i_prev_after,
    input  logic signed [SAMPLE_BITS-1:0] i_next_v,
    input  logic                          i_next_valid,
    input  logic                          i_next_le,
    output logic signed [SAMPLE_BITS-1:0] o_v,
    output logic                          o_valid,
    output logic                          o_after,
    output logic                          o_le
);
    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_v;
    logic signed [SAMPLE_BITS-1:0] n_v;
    logic                          r_valid;
    logic                          n_valid;

    assign o_v     = r_v;
    assign o_valid = r_valid;
    assign o_after = !r_valid || (r_v > i_x);
    assign o_le    = r_valid && (r_v <= i_y);

    always_comb begin
        n_v     = r_v;
        n_valid = r_valid;
        priority if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.ins && o_after) begin
            n_v     = i_prev_after ? i_prev_v : i_x;
            n_valid = i_prev_valid;
        end else if (i_ctl.del && !i_next_le) begin
            n_v     = i_next_v;
            n_valid = i_next_valid;
        end else begin
            n_v     = r_v;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
    end

endmodule

>>> rtl/swm_history.sv
// Ring memory of samples in arrival order, one write and one registered read port.
// Contents are undefined until written. Uses swm_pkg.
module swm_history #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic signed [SAMPLE_BITS-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic signed [SAMPLE_BITS-1:0] o_rdata
);
    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/sliding_window_median.sv
// Sliding window median filter: lower median of the last window_size samples.
// A result word is registered from the cell chain after its sample word has been
// inserted, once the chain holds a full window. A new sample word is taken only
// after the chain has inserted the last one and, when the window is full, retired
// the oldest; a result word not yet taken holds the retire step until it is taken.
// Reset clears the chain valid bits, fill count and ring pointer and sets the
// window to five; the sample ring is not cleared and needs no clearing pass.
module sliding_window_median #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    swm_in_if.sink                             i_in,
    swm_out_if.source                          o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [swm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [swm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import swm_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int RST_WS = int'(WINDOW_SIZE_RST);
    localparam int RST_K = (RST_WS < 1) ? 1 : ((RST_WS > MAX_WINDOW) ? MAX_WINDOW : RST_WS);

    localparam logic ST_IN  = 1'b0;
    localparam logic ST_OUT = 1'b1;

    logic                          r_state;
    logic [WS_W-1:0]               r_ws;
    logic [CW-1:0]                 r_k;
    logic [AW-1:0]                 r_rank;
    logic [CW-1:0]                 r_fill;
    logic [AW-1:0]                 r_wp;
    logic                          r_full;
    logic                          r_same;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_median;

    logic                          w_cfg_wr;
    logic                          w_take;
    logic                          w_load;
    int                            w_ws_i;
    int                            w_k_i;
    int                            w_wp_inc;
    logic [AW-1:0]                 w_wp_next;
    logic signed [SAMPLE_BITS-1:0] w_hist_rd;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic signed [SAMPLE_BITS-1:0] w_med;
    t_cell_ctl                     w_ctl;

    logic signed [SAMPLE_BITS-1:0] w_v     [MAX_WINDOW];
    logic                          w_valid [MAX_WINDOW];
    logic                          w_after [MAX_WINDOW];
    logic                          w_le    [MAX_WINDOW];

    assign pready = 1'b1;
    assign prdata = {{(CFG_DATA_W - WS_W){1'b0}}, r_ws};
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_SIZE);

    assign i_in.ready  = (r_state == ST_IN);
    assign o_out.valid = r_out_valid;
    assign o_out.median = r_median;

    assign w_take = i_in.valid && (r_state == ST_IN);
    assign w_load = (r_state == ST_OUT) && r_full && (!r_out_valid || o_out.ready);

    always_comb begin
        w_ws_i = int'(pwdata[WS_W-1:0]);
        if (w_ws_i < 1) begin
            w_k_i = 1;
        end else if (w_ws_i > MAX_WINDOW) begin
            w_k_i = MAX_WINDOW;
        end else begin
            w_k_i = w_ws_i;
        end
    end

    always_comb begin
        w_wp_inc = int'(r_wp) + 1;
        w_wp_next = (w_wp_inc >= int'(r_k)) ? '0 : AW'(w_wp_inc);
    end

    always_comb begin
        w_ctl.clr = w_cfg_wr;
        w_ctl.ins = w_take;
        w_ctl.del = w_load;
    end

    assign w_y = r_same ? r_x : w_hist_rd;

    swm_history #(
        .DEPTH       (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (w_take),
        .i_waddr (r_wp),
        .i_wdata (i_in.sample),
        .i_re    (w_take),
        .i_raddr (w_wp_next),
        .o_rdata (w_hist_rd)
    );

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_pv;
        logic                          w_pvalid;
        logic                          w_pafter;
        logic signed [SAMPLE_BITS-1:0] w_nv;
        logic                          w_nvalid;
        logic                          w_nle;

        if (g == 0) begin : g_first
            assign w_pv     = '0;
            assign w_pvalid = 1'b1;
            assign w_pafter = 1'b0;
        end else begin : g_mid_prev
            assign w_pv     = w_v[g-1];
            assign w_pvalid = w_valid[g-1];
            assign w_pafter = w_after[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign w_nv     = '0;
            assign w_nvalid = 1'b0;
            assign w_nle    = 1'b0;
        end else begin : g_mid_next
            assign w_nv     = w_v[g+1];
            assign w_nvalid = w_valid[g+1];
            assign w_nle    = w_le[g+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_x          (i_in.sample),
            .i_y          (w_y),
            .i_prev_v     (w_pv),
            .i_prev_valid (w_pvalid),
            .i_prev_after (w_pafter),
            .i_next_v     (w_nv),
            .i_next_valid (w_nvalid),
            .i_next_le    (w_nle),
            .o_v          (w_v[g]),
            .o_valid      (w_valid[g]),
            .o_after      (w_after[g]),
            .o_le         (w_le[g])
        );
    end

    always_comb begin
        w_med = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            w_med = w_med | (w_v[i] & {SAMPLE_BITS{r_rank == AW'(i)}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IN;
            r_ws        <= WINDOW_SIZE_RST;
            r_k         <= CW'(RST_K);
            r_rank      <= AW'((RST_K - 1) >> 1);
            r_fill      <= '0;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_ws   <= pwdata[WS_W-1:0];
                r_k    <= CW'(w_k_i);
                r_rank <= AW'((w_k_i - 1) >> 1);
                r_fill <= '0;
                r_wp   <= '0;
            end else if (w_take) begin
                r_wp    <= w_wp_next;
                r_full  <= (CW'(int'(r_fill) + 1) == r_k);
                r_state <= ST_OUT;
            end else if (r_state == ST_OUT) begin
                if (!r_full) begin
                    r_fill  <= CW'(int'(r_fill) + 1);
                    r_state <= ST_IN;
                end else if (w_load) begin
                    r_state <= ST_IN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_x    <= i_in.sample;
            r_same <= (w_wp_next == r_wp);
        end
        if (w_load) begin
            r_median <= w_med;
        end
    end

endmodule
